>>> src/sbta_pkg.sv
// Shared types and constants for the sequencer play head.
// Holds the request codes, register indexes, microcode word layout and the control ROM.
// No dependencies.
package sbta_pkg;

  localparam int TICK_BITS_DEF = 32;
  localparam int TIME_BITS_DEF = 32;
  localparam int DIV_W_DEF     = 33;

  localparam logic [31:0] TIME_RESET = 32'h0001_0000;

  localparam logic CFG_TICK_PERIOD    = 1'b0;
  localparam logic CFG_BLOCK_DURATION = 1'b1;

  typedef enum logic [1:0] {
    REQ_ADVANCE = 2'd0,
    REQ_SEEK    = 2'd1,
    REQ_PHASE   = 2'd2,
    REQ_LOOP    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OP_LATCH,
    OP_DISPATCH,
    OP_ADV_INIT,
    OP_DIV_STEP,
    OP_ADV_POS,
    OP_ADV_WRAP,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_REQ,
    COND_NOT_ADVANCE,
    COND_S_ZERO,
    COND_DIV_BUSY,
    COND_NO_WRAP,
    COND_OUT_BUSY
  } cond_t;

  localparam int UPC_BITS = 3;
  typedef logic [UPC_BITS-1:0] upc_t;

  localparam upc_t ST_IDLE     = 3'd0;
  localparam upc_t ST_DISPATCH = 3'd1;
  localparam upc_t ST_INIT     = 3'd2;
  localparam upc_t ST_DIV_N    = 3'd3;
  localparam upc_t ST_POS      = 3'd4;
  localparam upc_t ST_DIV_WRAP = 3'd5;
  localparam upc_t ST_WRAP     = 3'd6;
  localparam upc_t ST_DONE     = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uop_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // Control program: jump to target when cond holds, else fall through to the next step.
  function automatic uop_t ucode(upc_t pc);
    uop_t u;
    unique case (pc)
      ST_IDLE:     u = '{op: OP_LATCH,    cond: COND_NO_REQ,      target: ST_IDLE};
      ST_DISPATCH: u = '{op: OP_DISPATCH, cond: COND_NOT_ADVANCE, target: ST_DONE};
      ST_INIT:     u = '{op: OP_ADV_INIT, cond: COND_S_ZERO,      target: ST_DONE};
      ST_DIV_N:    u = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY,    target: ST_DIV_N};
      ST_POS:      u = '{op: OP_ADV_POS,  cond: COND_NO_WRAP,     target: ST_DONE};
      ST_DIV_WRAP: u = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY,    target: ST_DIV_WRAP};
      ST_WRAP:     u = '{op: OP_ADV_WRAP, cond: COND_NONE,        target: ST_IDLE};
      ST_DONE:     u = '{op: OP_OUT,      cond: COND_OUT_BUSY,    target: ST_DONE};
    endcase
    return u;
  endfunction

endpackage

>>> src/sequencer_block_tick_advance.sv
// Sequencer play head: top level, microcoded control and datapath.
// Depends on sbta_pkg and sbta_div.
//
// Usage:
//   Requests enter on in_valid/in_ready with req_type and its operands. Each request
//   yields one result on out_valid/out_ready: tick position, time since the last
//   tick and the looping flag. tick_period and block_duration are written through
//   cfg_we/cfg_index/cfg_data while no request is in flight.
//   Seek, set phase and set loop pass through dispatch to the output step. An
//   advance runs the tick count through the shared one-bit-per-cycle divider
//   (DIV_W = max(TIME_BITS, TICK_BITS) + 1 bits wide, 33 at the default widths)
//   and, when a loop wrap occurs, runs the wrap offset through it as well.
//   One request is in work at a time; the next is accepted in the cycle
//   after the result is loaded into the output register.
//   A waiting result does not block acceptance; a finished request holds in its
//   last step until the output register frees up.
//   Reset: in_ready low, position, phase and loop range clear, looping off,
//   tick_period and block_duration return to 1.0 ms, output register empty.
module sequencer_block_tick_advance import sbta_pkg::*; #(
  parameter int TICK_BITS = TICK_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] new_position,
  input  logic [31:0] new_phase,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] tick_position,
  output logic [31:0] time_since_tick,
  output logic        looping
);

  localparam int DIV_W = (TIME_BITS > TICK_BITS) ? TIME_BITS + 1 : TICK_BITS + 1;

  // Steps from x until the first step that lands on the loop start.
  function automatic logic [TICK_BITS:0] steps_to_jump(logic [TICK_BITS-1:0] x,
                                                       logic [TICK_BITS-1:0] stop);
    logic [TICK_BITS:0] r;
    if (x < stop) begin
      r = {1'b0, stop} - {1'b0, x};
    end else if (x != {TICK_BITS{1'b1}} || stop == '0) begin
      r = (TICK_BITS+1)'(1);
    end else begin
      r = {1'b0, stop} + 1'b1;
    end
    return r;
  endfunction

  upc_t pc;
  upc_t pc_next;
  uop_t uop;
  logic taken;

  logic [TIME_BITS-1:0] tick_period;
  logic [TIME_BITS-1:0] block_duration;
  logic [TICK_BITS-1:0] position;
  logic [TIME_BITS-1:0] phase;
  logic                 loop_on;
  logic [TICK_BITS-1:0] loop_first;
  logic [TICK_BITS-1:0] loop_stop;

  req_t                 req_kind;
  logic [TICK_BITS-1:0] req_pos;
  logic [TIME_BITS-1:0] req_phase;
  logic [TICK_BITS-1:0] req_start;
  logic [TICK_BITS-1:0] req_end;

  logic                 accept;
  logic                 out_free;
  logic [TIME_BITS:0]   s_sum;
  logic                 s_zero;
  logic [TIME_BITS-1:0] t_eff;
  logic [TICK_BITS:0]   first;
  logic [TICK_BITS:0]   cycle;
  logic [DIV_W-1:0]     first_ext;
  logic                 wrap;
  logic [DIV_W-1:0]     rest;

  div_ctl_t         div_ctl;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_rem;
  logic             div_last;

  sbta_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .remainder(div_rem),
    .last     (div_last)
  );

  assign uop      = ucode(pc);
  assign in_ready = (pc == ST_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Advance math: ticks n = (S - 1) / T, new phase = remainder + 1.
  assign s_sum     = {1'b0, block_duration} + {1'b0, phase};
  assign s_zero    = s_sum == '0;
  assign t_eff     = (tick_period == '0) ? TIME_BITS'(1) : tick_period;
  assign first     = steps_to_jump(position, loop_stop);
  assign cycle     = steps_to_jump(loop_first, loop_stop);
  assign first_ext = DIV_W'(first);
  assign wrap      = loop_on && (div_quo >= first_ext);
  assign rest      = div_quo - first_ext;

  always_comb begin
    div_ctl.load = (uop.op == OP_ADV_INIT) || (uop.op == OP_ADV_POS && wrap);
    div_ctl.step = uop.op == OP_DIV_STEP;
    if (uop.op == OP_ADV_INIT) begin
      div_dividend = DIV_W'(s_sum - 1'b1);
      div_divisor  = DIV_W'(t_eff);
    end else begin
      div_dividend = rest;
      div_divisor  = DIV_W'(cycle);
    end
  end

  always_comb begin
    unique case (uop.cond)
      COND_NONE:        taken = 1'b0;
      COND_NO_REQ:      taken = !in_valid;
      COND_NOT_ADVANCE: taken = req_kind != REQ_ADVANCE;
      COND_S_ZERO:      taken = s_zero;
      COND_DIV_BUSY:    taken = !div_last;
      COND_NO_WRAP:     taken = !wrap;
      COND_OUT_BUSY:    taken = !out_free;
      default:          taken = 1'b0;
    endcase
    // fall through from the last step wraps back to idle
    pc_next = taken ? uop.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period    <= TIME_BITS'(TIME_RESET);
      block_duration <= TIME_BITS'(TIME_RESET);
      position       <= '0;
      phase          <= '0;
      loop_on        <= 1'b0;
      loop_first     <= '0;
      loop_stop      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TICK_PERIOD:    tick_period    <= TIME_BITS'(cfg_data);
          CFG_BLOCK_DURATION: block_duration <= TIME_BITS'(cfg_data);
          default: ;
        endcase
      end
      unique case (uop.op)
        OP_DISPATCH: begin
          unique case (req_kind)
            REQ_SEEK:  position <= req_pos;
            REQ_PHASE: phase <= req_phase;
            REQ_LOOP: begin
              loop_first <= req_start;
              loop_stop  <= req_end;
              loop_on    <= 1'b1;
              if (!(position >= req_start && position < req_end)) begin
                position <= req_start;
              end
            end
            default: ;
          endcase
        end
        OP_ADV_INIT: begin
          if (s_zero) begin
            phase <= '0;
          end
        end
        OP_ADV_POS: begin
          phase <= TIME_BITS'(div_rem + DIV_W'(1));
          if (!wrap) begin
            position <= TICK_BITS'(DIV_W'(position) + div_quo);
          end
        end
        OP_ADV_WRAP: position <= TICK_BITS'(DIV_W'(loop_first) + div_rem);
        default: ;
      endcase
      if (uop.op == OP_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request latch and output register.
  always_ff @(posedge clk) begin
    if (uop.op == OP_LATCH && accept) begin
      req_kind  <= req_t'(req_type);
      req_pos   <= TICK_BITS'(new_position);
      req_phase <= TIME_BITS'(new_phase);
      req_start <= TICK_BITS'(range_start);
      req_end   <= TICK_BITS'(range_end);
    end
    if (uop.op == OP_OUT && out_free) begin
      tick_position   <= 32'(position);
      time_since_tick <= 32'(phase);
      looping         <= loop_on;
    end
  end

endmodule

>>> src/sbta_div.sv
// Restoring divider, one quotient bit per cycle while stepped.
// Loaded and stepped by the play head sequencer; uses sbta_pkg for the control struct.
module sbta_div import sbta_pkg::*; #(
  parameter int DIV_W = DIV_W_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder,
  output logic             last
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   shifted;
  logic             fits;

  assign shifted = {remainder, quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign last    = cnt == CNT_W'(DIV_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.load) begin
      cnt <= '0;
    end else if (ctl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (ctl.step) begin
      quotient <= {quotient[DIV_W-2:0], fits};
      if (fits) begin
        remainder <= DIV_W'(shifted - {1'b0, dsr});
      end else begin
        remainder <= shifted[DIV_W-1:0];
      end
    end
  end

endmodule

>>> dv/play_head_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the sequencer play head: watches config writes and both request channels,
// predicts each result from its own copy of the play head state and compares field by field.
// Depends on sbta_pkg.
module play_head_checker import sbta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] new_position,
  input  logic [31:0] new_phase,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] tick_position,
  input  logic [31:0] time_since_tick,
  input  logic        looping,
  output int          pending,
  output int          failures
);

  localparam logic [63:0] TICK_MASK = 64'hFFFF_FFFF;
  localparam logic [63:0] TIME_MASK = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] phase;
    logic        looping;
  } head_t;

  logic [31:0] period_reg;
  logic [31:0] block_reg;
  logic [63:0] head_pos;
  logic [63:0] head_phase;
  logic [63:0] loop_first;
  logic [63:0] loop_stop;
  logic        loop_on;
  head_t       expected_heads[$];
  int          fail_count = 0;

  // Steps from x until the first step that lands on loop_first.
  function automatic logic [63:0] steps_to_loop_jump(logic [63:0] x);
    if (x < loop_stop) return loop_stop - x;
    if (x != TICK_MASK) return 64'd1;
    if (loop_stop == 64'd0) return 64'd1;
    return loop_stop + 64'd1;
  endfunction

  function automatic logic [63:0] stepped_position(logic [63:0] p, logic [63:0] n);
    logic [63:0] first;
    if (!loop_on) return (p + n) & TICK_MASK;
    first = steps_to_loop_jump(p);
    if (n < first) return (p + n) & TICK_MASK;
    return (loop_first + (n - first) % steps_to_loop_jump(loop_first)) & TICK_MASK;
  endfunction

  task automatic advance_block();
    logic [63:0] period;
    logic [63:0] span;
    logic [63:0] ticks;
    period = (period_reg == 32'd0) ? 64'd1 : {32'd0, period_reg};
    span   = {32'd0, block_reg} + head_phase;
    ticks  = (span == 64'd0) ? 64'd0 : (span - 64'd1) / period;
    head_phase = (span - ticks * period) & TIME_MASK;
    head_pos   = stepped_position(head_pos, ticks);
  endtask

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    head_t want;
    if (rst) begin
      period_reg = TIME_RESET;
      block_reg  = TIME_RESET;
      head_pos   = '0;
      head_phase = '0;
      loop_first = '0;
      loop_stop  = '0;
      loop_on    = 1'b0;
      expected_heads.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TICK_PERIOD) period_reg = cfg_data;
        else block_reg = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_heads.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, expected none, actual %h %h %b",
                   $time, tick_position, time_since_tick, looping);
        end else begin
          want = expected_heads.pop_front();
          if (tick_position !== want.position)
            report("tick_position", want.position, tick_position);
          if (time_since_tick !== want.phase)
            report("time_since_tick", want.phase, time_since_tick);
          if (looping !== want.looping)
            report("looping", {31'd0, want.looping}, {31'd0, looping});
        end
      end
      if (in_valid && in_ready) begin
        case (req_t'(req_type))
          REQ_ADVANCE: advance_block();
          REQ_SEEK:    head_pos = {32'd0, new_position};
          REQ_PHASE:   head_phase = {32'd0, new_phase};
          REQ_LOOP: begin
            loop_first = {32'd0, range_start};
            loop_stop  = {32'd0, range_end};
            loop_on    = 1'b1;
            // move into the range when outside, empty ranges included
            if (!(head_pos >= loop_first && head_pos < loop_stop)) head_pos = loop_first;
          end
        endcase
        expected_heads.push_back('{head_pos[31:0], head_phase[31:0], loop_on});
      end
    end
    pending  <= expected_heads.size();
    failures <= fail_count;
  end

endmodule

>>> dv/sequencer_block_tick_advance_tb.sv
`timescale 1ns / 1ps
// Testbench top for the sequencer play head: clock, reset, request stimulus and verdict.
// Depends on sbta_pkg, sequencer_block_tick_advance and play_head_checker.
module sequencer_block_tick_advance_tb;
  import sbta_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SEG_REQUESTS = 82;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic [31:0] new_position;
  logic [31:0] new_phase;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] tick_position;
  logic [31:0] time_since_tick;
  logic        looping;
  int          pending;
  int          failures;

  int send_idle_pct = 0;
  int recv_idle_pct = 30;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;
  int kind_count[4] = '{0, 0, 0, 0};
  int settings = 1;

  sequencer_block_tick_advance dut (.*);

  play_head_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] pick_tick();
    case ($urandom_range(5))
      0, 1:    return $urandom;
      2:       return $urandom_range(40);
      3:       return 32'hFFFF_FFFF - $urandom_range(40);
      4:       return $urandom_range(4000);
      default: return 32'h8000_0000 + $urandom_range(40) - 32'd20;
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(4))
      0:       return $urandom;
      1:       return $urandom_range(64);
      2:       return $urandom_range(32'h3_0000);
      3:       return 32'hFFFF_FFFF - $urandom_range(64);
      default: return 32'd0;
    endcase
  endfunction

  task automatic offer(req_t kind, logic [31:0] pos, logic [31:0] ph,
                       logic [31:0] first, logic [31:0] stop);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    new_position <= pos;
    new_phase    <= ph;
    range_start  <= first;
    range_end    <= stop;
    do @(posedge clk); while (!in_ready);
    kind_count[kind]++;
  endtask

  // Mostly advances; loop ranges are usually well formed and short so wraps happen often.
  task automatic offer_random();
    int roll;
    logic [31:0] first;
    logic [31:0] stop;
    roll  = $urandom_range(99);
    first = pick_tick();
    stop  = ($urandom_range(99) < 80) ? first + $urandom_range(1, 24) : pick_tick();
    if (roll < 55) offer(REQ_ADVANCE, pick_tick(), pick_time(), first, stop);
    else if (roll < 68) offer(REQ_SEEK, pick_tick(), pick_time(), first, stop);
    else if (roll < 78) offer(REQ_PHASE, pick_tick(), pick_time(), first, stop);
    else offer(REQ_LOOP, pick_tick(), pick_time(), first, stop);
  endtask

  task automatic set_config(logic [31:0] period, logic [31:0] span);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TICK_PERIOD;
    cfg_data  <= period;
    @(posedge clk);
    cfg_index <= CFG_BLOCK_DURATION;
    cfg_data  <= span;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Wait until every expected result has come back and the block sits idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_TICK_PERIOD;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    req_type     <= REQ_ADVANCE;
    new_position <= '0;
    new_phase    <= '0;
    range_start  <= '0;
    range_end    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no loop yet: plain steps, overdue ticks and position wrap
    offer(REQ_ADVANCE, '0, '0, '0, '0);
    offer(REQ_ADVANCE, '0, '0, '0, '0);
    offer(REQ_PHASE, '0, 32'hFFFF_FFFF, '0, '0);
    offer(REQ_ADVANCE, '0, '0, '0, '0);
    offer(REQ_SEEK, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(REQ_ADVANCE, '0, '0, '0, '0);

    // zero tick period and widest block
    drain();
    set_config(32'd0, 32'hFFFF_FFFF);
    offer(REQ_ADVANCE, '0, '0, '0, '0);
    offer(REQ_PHASE, '0, 32'hFFFF_FFFF, '0, '0);
    offer(REQ_ADVANCE, '0, '0, '0, '0);

    // widest period, empty block
    drain();
    set_config(32'hFFFF_FFFF, 32'd0);
    offer(REQ_PHASE, '0, '0, '0, '0);
    offer(REQ_ADVANCE, '0, '0, '0, '0);
    offer(REQ_PHASE, '0, 32'hFFFF_FFFF, '0, '0);
    offer(REQ_ADVANCE, '0, '0, '0, '0);

    // loop ranges: normal, empty, position above the end, end at zero
    drain();
    set_config(32'd1, 32'd40);
    offer(REQ_LOOP, '0, '0, 32'd2, 32'd5);
    offer(REQ_ADVANCE, '0, '0, '0, '0);
    offer(REQ_LOOP, '0, '0, 32'd7, 32'd3);
    offer(REQ_ADVANCE, '0, '0, '0, '0);
    offer(REQ_LOOP, '0, '0, 32'd5, 32'hFFFF_FFFF);
    offer(REQ_SEEK, 32'hFFFF_FFFF, '0, '0, '0);
    offer(REQ_ADVANCE, '0, '0, '0, '0);
    offer(REQ_LOOP, '0, '0, 32'd16, 32'd0);
    offer(REQ_SEEK, 32'hFFFF_FFFF, '0, '0, '0);
    offer(REQ_ADVANCE, '0, '0, '0, '0);
    offer(REQ_LOOP, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(REQ_ADVANCE, '0, '0, '0, '0);

    for (int phase_idx = 0; phase_idx < 3; phase_idx++) begin
      send_idle_pct = (phase_idx == 0) ? 13 : (phase_idx == 1) ? 67 : 0;
      recv_idle_pct = (phase_idx == 0) ? 67 : (phase_idx == 1) ? 13 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        drain();
        case ($urandom_range(5))
          0:       set_config($urandom_range(1, 16), $urandom_range(64));
          1:       set_config(32'h1_0000 + $urandom_range(2048) - 32'd1024,
                              $urandom_range(32'h4_0000));
          2:       set_config($urandom, $urandom);
          3:       set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
          4:       set_config(32'd1, $urandom);
          default: set_config($urandom_range(1, 32'hFFFF), $urandom_range(32'hF_FFFF));
        endcase
        // fill the block up against a stalled receiver
        if (phase_idx == 2 && seg == 0) hold_off = 1'b1;
        repeat (SEG_REQUESTS) offer_random();
      end
    end

    drain();
    repeat (80) @(posedge clk);
    $display("Covered %0d advance, %0d seek, %0d phase and %0d loop-range requests",
             kind_count[REQ_ADVANCE], kind_count[REQ_SEEK], kind_count[REQ_PHASE],
             kind_count[REQ_LOOP]);
    $display("across %0d register settings, with idle, stalled and back-to-back traffic",
             settings);
    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
